// ===== hw/rtl/mspg_pkg.sv =====
// Package for the multi-axis step pulse generator: field widths, codes,
// the item and result structs shared by the top level and the core.
// No dependencies.
`default_nettype none

package mspg_pkg;

	// Defaults for the top-level parameters
	localparam int AXES_DEF      = 4;
	localparam int CLOCK_MHZ_DEF = 100;

	// Field widths
	localparam int KIND_W     = 2;
	localparam int US_W       = 20;
	localparam int COUNT_W    = 16;
	localparam int LEVEL_W    = 4;
	localparam int STEPS_W    = 16;
	localparam int TIME_W     = 32;
	localparam int HP_W       = 32;
	localparam int EDGE_W     = 17;
	localparam int AXCNT_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_INV   = 2'd2;

	// Request after input decode: half-period and edge count precomputed
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              direction;
		logic [HP_W-1:0]   half_period;
		logic [EDGE_W-1:0] edges;
	} item_t;

	// One result
	typedef struct packed {
		logic [LEVEL_W-1:0] step_levels;
		logic [LEVEL_W-1:0] dir_levels;
		logic               busy_res;
		logic               report_valid;
		logic [STEPS_W-1:0] report_steps;
		logic [TIME_W-1:0]  report_time;
		logic               finished;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mspg_if.sv =====
// Valid/ready channel interfaces for the step pulse generator:
// the request channel and the result channel. Depends on mspg_pkg.
`default_nettype none

interface mspg_item_if;
	logic                              valid;
	logic                              ready;
	logic [mspg_pkg::KIND_W-1:0]       kind;
	logic                              direction;
	logic [mspg_pkg::US_W-1:0]         step_us;
	logic [mspg_pkg::COUNT_W-1:0]      step_count;

	modport source (output valid, kind, direction, step_us, step_count, input ready);
	modport sink   (input valid, kind, direction, step_us, step_count, output ready);
endinterface

interface mspg_result_if;
	logic                              valid;
	logic                              ready;
	logic [mspg_pkg::LEVEL_W-1:0]      step_levels;
	logic [mspg_pkg::LEVEL_W-1:0]      dir_levels;
	logic                              busy_res;
	logic                              report_valid;
	logic [mspg_pkg::STEPS_W-1:0]      report_steps;
	logic [mspg_pkg::TIME_W-1:0]       report_time;
	logic                              finished;

	modport source (output valid, step_levels, dir_levels, busy_res, report_valid,
		report_steps, report_time, finished, input ready);
	modport sink   (input valid, step_levels, dir_levels, busy_res, report_valid,
		report_steps, report_time, finished, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mspg_core.sv =====
// Move state of the step pulse generator: configuration registers, pin
// levels, edge and half-period counters, and the per-request update.
// Depends on mspg_pkg.
`default_nettype none

module mspg_core #(
	parameter int AXES = mspg_pkg::AXES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mspg_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [mspg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              fire,
	input  wire mspg_pkg::item_t                   item,
	output mspg_pkg::result_t                      res
);

	localparam int LW = mspg_pkg::LEVEL_W;
	localparam int EW = mspg_pkg::EDGE_W;
	localparam int HW = mspg_pkg::HP_W;
	localparam int TW = mspg_pkg::TIME_W;

	// Configuration
	logic [mspg_pkg::AXCNT_W-1:0] axis_count_q;
	logic [AXES-1:0]              dir_inv_q;

	// Move state
	logic            running_q, running_n;
	logic            stop_q, stop_n;
	logic [EW-1:0]   edges_q, edges_n;
	logic [EW-1:0]   start_q, start_n;
	logic [HW-1:0]   half_q, half_n;
	logic [HW-1:0]   cd_q, cd_n;
	logic [AXES-1:0] step_q, step_n;
	logic [AXES-1:0] dir_q, dir_n;
	logic [AXES-1:0] saved_q, saved_n;
	logic [TW-1:0]   tick_q, tick_n;

	logic [AXES-1:0] en;
	logic [AXES-1:0] cfg_fit;
	logic [LW-1:0]   step_lvl, dir_lvl;

	// Enabled axes: counts above AXES enable all of them
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			en[i] = (int'(axis_count_q) > i);
		end
	end

	// Fit the 4-bit masks and level fields to the AXES axes
	for (genvar i = 0; i < AXES; i++) begin : g_cfg_fit
		if (i < LW) begin : g_in
			assign cfg_fit[i] = cfg_data[i];
		end else begin : g_out
			assign cfg_fit[i] = 1'b0;
		end
	end

	for (genvar i = 0; i < LW; i++) begin : g_lvl
		if (i < AXES) begin : g_in
			assign step_lvl[i] = step_n[i];
			assign dir_lvl[i]  = dir_n[i];
		end else begin : g_out
			assign step_lvl[i] = 1'b0;
			assign dir_lvl[i]  = 1'b0;
		end
	end

	// Per-request update
	always_comb begin
		logic [HW-1:0]   cd_dec;
		logic [EW-1:0]   e_dec;
		logic [AXES-1:0] want;

		running_n = running_q;
		stop_n    = stop_q;
		edges_n   = edges_q;
		start_n   = start_q;
		half_n    = half_q;
		cd_n      = cd_q;
		step_n    = step_q;
		dir_n     = dir_q;
		saved_n   = saved_q;
		tick_n    = tick_q;
		cd_dec    = cd_q - HW'(1);
		e_dec     = edges_q - EW'(1);
		want      = item.direction ? (~dir_inv_q & en) : (dir_inv_q & en);
		res.report_valid = 1'b0;
		res.finished     = 1'b0;
		res.report_steps = '0;
		res.report_time  = '0;

		unique case (item.kind)
			mspg_pkg::KIND_STOP: begin
				stop_n = 1'b1;
			end
			mspg_pkg::KIND_RUN: begin
				stop_n    = 1'b0;
				saved_n   = dir_q;
				dir_n     = (dir_q & ~en) | want;
				half_n    = item.half_period;
				cd_n      = item.half_period;
				edges_n   = item.edges;
				start_n   = item.edges;
				running_n = 1'b1;
			end
			mspg_pkg::KIND_TICK: begin
				tick_n = tick_q + TW'(1);
				if (running_q) begin
					cd_n = cd_dec;
					if (cd_dec == '0) begin
						step_n  = step_q ^ en;
						edges_n = e_dec;
						if (e_dec == '0 || (!e_dec[0] && stop_q)) begin
							// End of move: final report, restore directions
							res.report_valid = 1'b1;
							res.finished     = 1'b1;
							res.report_steps = e_dec[EW-1:1];
							res.report_time  = tick_n;
							dir_n     = (dir_q & ~en) | (saved_q & en);
							stop_n    = 1'b0;
							running_n = 1'b0;
						end else begin
							// Report after the first edge only
							if (e_dec == start_q - EW'(1)) begin
								res.report_valid = 1'b1;
								res.report_steps = e_dec[EW-1:1];
								res.report_time  = tick_n;
							end
							cd_n = half_q;
						end
					end
				end
			end
			default: begin
			end
		endcase

		res.step_levels = step_lvl;
		res.dir_levels  = dir_lvl;
		res.busy_res    = running_n;
	end

	// State registers; configuration writes are for the user to make only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_count_q <= '0;
			dir_inv_q    <= '0;
			running_q    <= 1'b0;
			stop_q       <= 1'b0;
			edges_q      <= '0;
			start_q      <= '0;
			half_q       <= '0;
			cd_q         <= '0;
			step_q       <= '0;
			dir_q        <= '0;
			saved_q      <= '0;
			tick_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mspg_pkg::CFG_AXIS_COUNT: axis_count_q <= cfg_data[mspg_pkg::AXCNT_W-1:0];
				mspg_pkg::CFG_DIR_INVERT: dir_inv_q    <= cfg_fit;
				mspg_pkg::CFG_STEP_INV:   step_q       <= cfg_fit;
				default: begin
				end
			endcase
		end else if (fire) begin
			running_q <= running_n;
			stop_q    <= stop_n;
			edges_q   <= edges_n;
			start_q   <= start_n;
			half_q    <= half_n;
			cd_q      <= cd_n;
			step_q    <= step_n;
			dir_q     <= dir_n;
			saved_q   <= saved_n;
			tick_q    <= tick_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_axis_step_pulse_generator_top.sv =====
// Multi-axis step pulse generator: step and direction levels for up to AXES
// stepper axes, driven by a stream of tick, run and stop requests.
//
// Channels: din takes requests (tick, run, stop), dout gives one result per
// request (pin levels, busy flag and an optional progress report). Both are
// valid/ready; a request moves when valid and ready are high at a clock edge.
// cfg_we/cfg_idx/cfg_data write axis count, direction invert and step invert
// (the last one also loads the step pin levels); write only while idle.
// Timing: an accepted request waits in the input register; its result is
// registered as it moves on and offered on dout from then on. Throughput:
// one request per cycle while dout is not held, set by the single input
// and result registers, with the state update done in one pass between them.
// Stall: while dout is held, one finished result waits in the result
// register and one more request is taken into the input register; then
// din.ready drops until dout moves.
// Reset: all pin levels, counters and configuration clear to zero, no move
// is running and both stages are empty.
// Depends on mspg_pkg, mspg_if and mspg_core.
`default_nettype none

module multi_axis_step_pulse_generator_top #(
	parameter int AXES      = mspg_pkg::AXES_DEF,
	parameter int CLOCK_MHZ = mspg_pkg::CLOCK_MHZ_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	mspg_item_if.sink                              din,
	mspg_result_if.source                          dout,
	input  wire logic                              cfg_we,
	input  wire logic [mspg_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [mspg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int HW = mspg_pkg::HP_W;

	logic              v_s1;
	mspg_pkg::item_t   item_s1;
	mspg_pkg::item_t   item_in;
	logic              v_s2;
	mspg_pkg::result_t res_s2;
	mspg_pkg::result_t res_c;
	logic              move;
	logic [HW-1:0]     prod;
	logic [HW-1:0]     hp_raw;

	// Request decode: half-period in timer ticks, edge count, zero-count run
	always_comb begin
		prod   = HW'(din.step_us) * HW'(CLOCK_MHZ);
		hp_raw = prod >> 1;
		item_in.direction   = din.direction;
		item_in.half_period = (hp_raw == '0) ? HW'(1) : hp_raw;
		item_in.edges       = {din.step_count, 1'b0};
		if (din.kind == mspg_pkg::KIND_RUN && din.step_count == '0) begin
			item_in.kind = mspg_pkg::KIND_STOP;
		end else begin
			item_in.kind = din.kind;
		end
	end

	// Handshake
	assign move      = v_s1 && (!v_s2 || dout.ready);
	assign din.ready = !v_s1 || move;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (din.valid && din.ready) begin
			v_s1 <= 1'b1;
		end else if (move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			item_s1 <= item_in;
		end
	end

	mspg_core #(
		.AXES(AXES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.fire     (move),
		.item     (item_s1),
		.res      (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (move) begin
			v_s2 <= 1'b1;
		end else if (dout.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_s2 <= res_c;
		end
	end

	assign dout.valid        = v_s2;
	assign dout.step_levels  = res_s2.step_levels;
	assign dout.dir_levels   = res_s2.dir_levels;
	assign dout.busy_res     = res_s2.busy_res;
	assign dout.report_valid = res_s2.report_valid;
	assign dout.report_steps = res_s2.report_steps;
	assign dout.report_time  = res_s2.report_time;
	assign dout.finished     = res_s2.finished;

endmodule

`default_nettype wire
